// ===== design/gjk_pkg.sv =====
// ----------------------------------------------------------------------------
// GJK simplex package
// Region codes, pipeline payload types and sizes shared by the closest-point
// pipeline.
// ----------------------------------------------------------------------------
package gjk_pkg;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 64;
  localparam int DIV_STEPS = 32;

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_C   = 3'd2,
    REG_AB  = 3'd3,
    REG_BC  = 3'd4,
    REG_CA  = 3'd5,
    REG_TRI = 3'd6
  } region_t;

  // Payload that rides along with an item down the divider stages.
  typedef struct packed {
    logic [1:0]         cnt;
    region_t            region;
    logic               is_edge;
    logic [COORD_W-1:0] v0x;
    logic [COORD_W-1:0] v0y;
    logic [COORD_W-1:0] v1x;
    logic [COORD_W-1:0] v1y;
    logic [COORD_W-1:0] v2x;
    logic [COORD_W-1:0] v2y;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [PROD_W-1:0]  d;
  } com_t;

  // One axis of the restoring divider.
  typedef struct packed {
    logic [PROD_W-1:0]  rem;
    logic [COORD_W-1:0] low;
    logic [COORD_W-1:0] q;
    logic               neg;
  } lane_t;

endpackage

// ===== design/gjk_simplex_closest_point.sv =====
// ----------------------------------------------------------------------------
// GJK simplex closest point
// Finds the feature of a 2D simplex closest to the origin and returns the
// reduced simplex, the closest point and a region code.
// An item passes stages 1 to 6, the divider setup register, the divider stages
// and the output register before its result shows on the output.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds when the output register is full and stalled.
// Edge points come from a 32-stage restoring divider, one quotient bit per
// stage, which sets the depth. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module gjk_simplex_closest_point
  import gjk_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 vertex_count,
  input  logic signed [COORD_W-1:0]  a_x,
  input  logic signed [COORD_W-1:0]  a_y,
  input  logic signed [COORD_W-1:0]  b_x,
  input  logic signed [COORD_W-1:0]  b_y,
  input  logic signed [COORD_W-1:0]  c_x,
  input  logic signed [COORD_W-1:0]  c_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 reduced_count,
  output logic signed [COORD_W-1:0]  out_a_x,
  output logic signed [COORD_W-1:0]  out_a_y,
  output logic signed [COORD_W-1:0]  out_b_x,
  output logic signed [COORD_W-1:0]  out_b_y,
  output logic signed [COORD_W-1:0]  out_c_x,
  output logic signed [COORD_W-1:0]  out_c_y,
  output logic signed [COORD_W-1:0]  closest_x,
  output logic signed [COORD_W-1:0]  closest_y,
  output logic [2:0]                 region
);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: vertices, negations and edge differences.
  logic v1;
  logic [1:0] s1_n;
  logic signed [COORD_W-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;
  logic signed [COORD_W-1:0] s1_nax, s1_nay, s1_nbx, s1_nby, s1_ncx, s1_ncy;
  logic signed [COORD_W-1:0] s1_abx, s1_aby, s1_bax, s1_bay;
  logic signed [COORD_W-1:0] s1_bcx, s1_bcy, s1_cbx, s1_cby;
  logic signed [COORD_W-1:0] s1_cax, s1_cay, s1_acx, s1_acy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_n   <= vertex_count;
      s1_ax  <= a_x;  s1_ay <= a_y;
      s1_bx  <= b_x;  s1_by <= b_y;
      s1_cx  <= c_x;  s1_cy <= c_y;
      s1_nax <= -a_x; s1_nay <= -a_y;
      s1_nbx <= -b_x; s1_nby <= -b_y;
      s1_ncx <= -c_x; s1_ncy <= -c_y;
      s1_abx <= a_x - b_x; s1_aby <= a_y - b_y;
      s1_bax <= b_x - a_x; s1_bay <= b_y - a_y;
      s1_bcx <= b_x - c_x; s1_bcy <= b_y - c_y;
      s1_cbx <= c_x - b_x; s1_cby <= c_y - b_y;
      s1_cax <= c_x - a_x; s1_cay <= c_y - a_y;
      s1_acx <= a_x - c_x; s1_acy <= a_y - c_y;
    end
  end

  // Stage 2: all dot and cross products, exact in 64 bits.
  logic v2;
  logic [1:0] s2_n;
  logic signed [COORD_W-1:0] s2_ax, s2_ay, s2_bx, s2_by, s2_cx, s2_cy;
  logic signed [PROD_W-1:0] p_uab_x, p_uab_y, p_vab_x, p_vab_y;
  logic signed [PROD_W-1:0] p_ubc_x, p_ubc_y, p_vbc_x, p_vbc_y;
  logic signed [PROD_W-1:0] p_uca_x, p_uca_y, p_vca_x, p_vca_y;
  logic signed [PROD_W-1:0] p_sa0, p_sa1, p_su0, p_su1, p_sv0, p_sv1, p_sw0, p_sw1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_n  <= s1_n;
      s2_ax <= s1_ax; s2_ay <= s1_ay;
      s2_bx <= s1_bx; s2_by <= s1_by;
      s2_cx <= s1_cx; s2_cy <= s1_cy;
      p_uab_x <= s1_nbx * s1_abx; p_uab_y <= s1_nby * s1_aby;
      p_vab_x <= s1_nax * s1_bax; p_vab_y <= s1_nay * s1_bay;
      p_ubc_x <= s1_ncx * s1_bcx; p_ubc_y <= s1_ncy * s1_bcy;
      p_vbc_x <= s1_nbx * s1_cbx; p_vbc_y <= s1_nby * s1_cby;
      p_uca_x <= s1_nax * s1_cax; p_uca_y <= s1_nay * s1_cay;
      p_vca_x <= s1_ncx * s1_acx; p_vca_y <= s1_ncy * s1_acy;
      p_sa0 <= s1_bax * s1_cay;   p_sa1 <= s1_bay * s1_cax;
      p_su0 <= s1_bx * s1_cy;     p_su1 <= s1_by * s1_cx;
      p_sv0 <= s1_cx * s1_ay;     p_sv1 <= s1_cy * s1_ax;
      p_sw0 <= s1_ax * s1_by;     p_sw1 <= s1_ay * s1_bx;
    end
  end

  // Stage 3: weights and cross-product signs.
  logic v3;
  logic [1:0] s3_n;
  logic signed [COORD_W-1:0] s3_ax, s3_ay, s3_bx, s3_by, s3_cx, s3_cy;
  logic [PROD_W-1:0] s3_uab, s3_vab, s3_ubc, s3_vbc, s3_uca, s3_vca;
  logic s3_ok_ab, s3_ok_bc, s3_ok_ca;
  logic signed [PROD_W-1:0] cr_a, cr_u, cr_v, cr_w;

  always_comb begin
    cr_a = p_sa0 - p_sa1;
    cr_u = p_su0 - p_su1;
    cr_v = p_sv0 - p_sv1;
    cr_w = p_sw0 - p_sw1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_n  <= s2_n;
      s3_ax <= s2_ax; s3_ay <= s2_ay;
      s3_bx <= s2_bx; s3_by <= s2_by;
      s3_cx <= s2_cx; s3_cy <= s2_cy;
      s3_uab <= p_uab_x + p_uab_y; s3_vab <= p_vab_x + p_vab_y;
      s3_ubc <= p_ubc_x + p_ubc_y; s3_vbc <= p_vbc_x + p_vbc_y;
      s3_uca <= p_uca_x + p_uca_y; s3_vca <= p_vca_x + p_vca_y;
      // A product of two signs is at most zero when either is zero or they differ.
      s3_ok_ab <= (cr_w == '0) || (cr_a == '0) || (cr_w[PROD_W-1] != cr_a[PROD_W-1]);
      s3_ok_bc <= (cr_u == '0) || (cr_a == '0) || (cr_u[PROD_W-1] != cr_a[PROD_W-1]);
      s3_ok_ca <= (cr_v == '0) || (cr_a == '0) || (cr_v[PROD_W-1] != cr_a[PROD_W-1]);
    end
  end

  // Stage 4: region choice and edge operands.
  logic v4;
  com_t s4_com;
  logic [PROD_W-1:0] s4_u, s4_v;
  logic [COORD_W-1:0] s4_px, s4_py, s4_qx, s4_qy;
  com_t dec_com;
  logic [PROD_W-1:0] dec_u, dec_v;
  logic [COORD_W-1:0] dec_px, dec_py, dec_qx, dec_qy;
  logic le_uab, le_vab, le_ubc, le_vbc, le_uca, le_vca;

  always_comb begin
    le_uab = s3_uab[PROD_W-1] || (s3_uab == '0);
    le_vab = s3_vab[PROD_W-1] || (s3_vab == '0);
    le_ubc = s3_ubc[PROD_W-1] || (s3_ubc == '0);
    le_vbc = s3_vbc[PROD_W-1] || (s3_vbc == '0);
    le_uca = s3_uca[PROD_W-1] || (s3_uca == '0);
    le_vca = s3_vca[PROD_W-1] || (s3_vca == '0);
    dec_com = '0;
    dec_u = s3_uab; dec_v = s3_vab;
    dec_px = s3_ax; dec_py = s3_ay; dec_qx = s3_bx; dec_qy = s3_by;
    dec_com.cnt = 2'd1;
    dec_com.region = REG_A;
    dec_com.v0x = s3_ax; dec_com.v0y = s3_ay;
    dec_com.fx  = s3_ax; dec_com.fy  = s3_ay;
    if (s3_n == 2'd2) begin
      if (le_vab) begin
        dec_com.region = REG_A;
      end else if (le_uab) begin
        dec_com.region = REG_B;
        dec_com.v0x = s3_bx; dec_com.v0y = s3_by;
        dec_com.fx  = s3_bx; dec_com.fy  = s3_by;
      end else begin
        dec_com.region = REG_AB;
        dec_com.is_edge = 1'b1;
      end
    end else if (s3_n == 2'd3) begin
      if (le_vab && le_uca) begin
        dec_com.region = REG_A;
      end else if (le_uab && le_vbc) begin
        dec_com.region = REG_B;
        dec_com.v0x = s3_bx; dec_com.v0y = s3_by;
        dec_com.fx  = s3_bx; dec_com.fy  = s3_by;
      end else if (le_ubc && le_vca) begin
        dec_com.region = REG_C;
        dec_com.v0x = s3_cx; dec_com.v0y = s3_cy;
        dec_com.fx  = s3_cx; dec_com.fy  = s3_cy;
      end else if (!le_uab && !le_vab && s3_ok_ab) begin
        dec_com.region = REG_AB;
        dec_com.is_edge = 1'b1;
      end else if (!le_ubc && !le_vbc && s3_ok_bc) begin
        dec_com.region = REG_BC;
        dec_com.is_edge = 1'b1;
        dec_u = s3_ubc; dec_v = s3_vbc;
        dec_px = s3_bx; dec_py = s3_by; dec_qx = s3_cx; dec_qy = s3_cy;
      end else if (!le_uca && !le_vca && s3_ok_ca) begin
        dec_com.region = REG_CA;
        dec_com.is_edge = 1'b1;
        dec_u = s3_uca; dec_v = s3_vca;
        dec_px = s3_cx; dec_py = s3_cy; dec_qx = s3_ax; dec_qy = s3_ay;
      end else begin
        dec_com.region = REG_TRI;
        dec_com.cnt = 2'd3;
        dec_com.v1x = s3_bx; dec_com.v1y = s3_by;
        dec_com.v2x = s3_cx; dec_com.v2y = s3_cy;
        dec_com.fx  = '0;    dec_com.fy  = '0;
      end
    end
    if (dec_com.is_edge) begin
      dec_com.cnt = 2'd2;
      dec_com.v0x = dec_px; dec_com.v0y = dec_py;
      dec_com.v1x = dec_qx; dec_com.v1y = dec_qy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_com <= dec_com;
      s4_u <= dec_u; s4_v <= dec_v;
      s4_px <= dec_px; s4_py <= dec_py; s4_qx <= dec_qx; s4_qy <= dec_qy;
    end
  end

  // Stage 5: 64x32 weight products as two 32x32 partial products each.
  logic v5;
  com_t s5_com;
  com_t s5_com_next;
  logic [PROD_W-1:0] pp_ulx, pp_uhx, pp_vlx, pp_vhx, pp_uly, pp_uhy, pp_vly, pp_vhy;
  logic s5_npx, s5_npy, s5_nqx, s5_nqy;
  logic [COORD_W-1:0] abs_px, abs_py, abs_qx, abs_qy;

  always_comb begin
    abs_px = s4_px[COORD_W-1] ? -s4_px : s4_px;
    abs_py = s4_py[COORD_W-1] ? -s4_py : s4_py;
    abs_qx = s4_qx[COORD_W-1] ? -s4_qx : s4_qx;
    abs_qy = s4_qy[COORD_W-1] ? -s4_qy : s4_qy;
    s5_com_next   = s4_com;
    s5_com_next.d = s4_u + s4_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_com <= s5_com_next;
      pp_ulx <= s4_u[31:0]  * abs_px;  pp_uhx <= s4_u[63:32] * abs_px;
      pp_vlx <= s4_v[31:0]  * abs_qx;  pp_vhx <= s4_v[63:32] * abs_qx;
      pp_uly <= s4_u[31:0]  * abs_py;  pp_uhy <= s4_u[63:32] * abs_py;
      pp_vly <= s4_v[31:0]  * abs_qy;  pp_vhy <= s4_v[63:32] * abs_qy;
      s5_npx <= s4_px[COORD_W-1]; s5_npy <= s4_py[COORD_W-1];
      s5_nqx <= s4_qx[COORD_W-1]; s5_nqy <= s4_qy[COORD_W-1];
    end
  end

  // Stage 6: assemble the 96-bit magnitudes.
  logic v6;
  com_t s6_com;
  logic [95:0] s6_max, s6_mbx, s6_may, s6_mby;
  logic s6_npx, s6_npy, s6_nqx, s6_nqy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_com <= s5_com;
      s6_max <= {32'd0, pp_ulx} + {pp_uhx, 32'd0};
      s6_mbx <= {32'd0, pp_vlx} + {pp_vhx, 32'd0};
      s6_may <= {32'd0, pp_uly} + {pp_uhy, 32'd0};
      s6_mby <= {32'd0, pp_vly} + {pp_vhy, 32'd0};
      s6_npx <= s5_npx; s6_npy <= s5_npy;
      s6_nqx <= s5_nqx; s6_nqy <= s5_nqy;
    end
  end

  // Stage 7: signed numerator and divider setup.
  function automatic lane_t lane_init(logic [95:0] ma, logic na, logic [95:0] mb, logic nb);
    logic [96:0] m;
    logic [96:0] diff;
    lane_t l;
    diff = {1'b0, ma} - {1'b0, mb};
    l.neg = na;
    if (na == nb) begin
      m = {1'b0, ma} + {1'b0, mb};
    end else if (diff[96]) begin
      m = {1'b0, mb} - {1'b0, ma};
      l.neg = nb;
    end else begin
      m = diff;
    end
    // The quotient fits 32 bits, so the upper part is already below the divisor.
    l.rem = m[95:32];
    l.low = m[31:0];
    l.q   = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [PROD_W-1:0] d);
    logic [PROD_W:0] t;
    logic [PROD_W:0] r;
    logic ge;
    lane_t o;
    t  = {l.rem, l.low[COORD_W-1]};
    r  = t - {1'b0, d};
    ge = !r[PROD_W] || t[PROD_W];
    o.rem = ge ? r[PROD_W-1:0] : t[PROD_W-1:0];
    o.low = {l.low[COORD_W-2:0], 1'b0};
    o.q   = {l.q[COORD_W-2:0], ge};
    o.neg = l.neg;
    return o;
  endfunction

  logic  dv   [0:DIV_STEPS];
  com_t  dcom [0:DIV_STEPS];
  lane_t dlx  [0:DIV_STEPS];
  lane_t dly  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      dcom[0] <= s6_com;
      dlx[0]  <= lane_init(s6_max, s6_npx, s6_mbx, s6_nqx);
      dly[0]  <= lane_init(s6_may, s6_npy, s6_mby, s6_nqy);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dcom[k] <= dcom[k-1];
        dlx[k]  <= lane_step(dlx[k-1], dcom[k-1].d);
        dly[k]  <= lane_step(dly[k-1], dcom[k-1].d);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (adv) begin
        dv[k] <= dv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; dv[0] <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; dv[0] <= v6; out_valid <= dv[DIV_STEPS];
    end
  end

  // Output register.
  com_t  fin;
  lane_t fin_x, fin_y;
  assign fin   = dcom[DIV_STEPS];
  assign fin_x = dlx[DIV_STEPS];
  assign fin_y = dly[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      reduced_count <= fin.cnt;
      region        <= fin.region;
      out_a_x <= fin.v0x; out_a_y <= fin.v0y;
      out_b_x <= fin.v1x; out_b_y <= fin.v1y;
      out_c_x <= fin.v2x; out_c_y <= fin.v2y;
      if (fin.is_edge) begin
        closest_x <= fin_x.neg ? -fin_x.q : fin_x.q;
        closest_y <= fin_y.neg ? -fin_y.q : fin_y.q;
      end else begin
        closest_x <= fin.fx;
        closest_y <= fin.fy;
      end
    end
  end

  a_tri_origin : assert property (@(posedge clk) disable iff (rst)
    (out_valid && region == REG_TRI) |-> (closest_x == '0 && closest_y == '0
      && reduced_count == 2'd3))
    else $error("interior result not at the origin");

  a_vertex_point : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (region == REG_A || region == REG_B || region == REG_C))
      |-> (reduced_count == 2'd1 && closest_x == out_a_x && closest_y == out_a_y
           && out_b_x == '0 && out_c_y == '0))
    else $error("vertex result inconsistent");

  a_edge_count : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (region == REG_AB || region == REG_BC || region == REG_CA))
      |-> (reduced_count == 2'd2 && out_c_x == '0 && out_c_y == '0))
    else $error("edge result inconsistent");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (out_valid && $stable(closest_x) && $stable(region)))
    else $error("pipeline moved while stalled");

endmodule

// ===== dv/tb_gjk_simplex_closest_point.sv =====
// ----------------------------------------------------------------------------
// GJK simplex closest point testbench
// Sends simplices of zero to three vertices through the closest-point pipeline
// and checks every result, field by field, against a fixed-point model of the
// vertex, edge and triangle region tests kept inside this bench. Directed
// items cover each region and the extreme coordinates; random items follow
// under three idling patterns on the two handshakes.
// ----------------------------------------------------------------------------
module tb_gjk_simplex_closest_point
  import gjk_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]  cnt;
    logic [31:0] f[8];   // vertices 0..2 (x,y), then closest x,y
    region_t     reg_code;
  } feature_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] vertex_count = '0;
  logic signed [31:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] reduced_count;
  logic signed [31:0] out_a_x, out_a_y, out_b_x, out_b_y, out_c_x, out_c_y;
  logic signed [31:0] closest_x, closest_y;
  logic [2:0] region;

  feature_t pending_features[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int region_hits[7];
  int cycles = 0;

  gjk_simplex_closest_point DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_count(vertex_count),
    .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .c_x(c_x), .c_y(c_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .reduced_count(reduced_count),
    .out_a_x(out_a_x), .out_a_y(out_a_y), .out_b_x(out_b_x), .out_b_y(out_b_y),
    .out_c_x(out_c_x), .out_c_y(out_c_y),
    .closest_x(closest_x), .closest_y(closest_y),
    .region(region)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gjk_simplex_closest_point verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
  end

  // Weight of p on edge p,q: dot(-q, p - q), differences wrapped to 32 bits.
  function automatic longint edge_weight(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] qx, logic signed [31:0] qy);
    logic signed [31:0] nx = -qx;
    logic signed [31:0] ny = -qy;
    logic signed [31:0] dx = px - qx;
    logic signed [31:0] dy = py - qy;
    return longint'(nx) * longint'(dx) + longint'(ny) * longint'(dy);
  endfunction

  function automatic int cross_sign(logic signed [31:0] ux, logic signed [31:0] uy,
                                    logic signed [31:0] vx, logic signed [31:0] vy);
    longint c = longint'(ux) * longint'(vy) - longint'(uy) * longint'(vx);
    return c > 0 ? 1 : (c < 0 ? -1 : 0);
  endfunction

  // (u*p + v*q) / (u + v), exact numerator, quotient truncated toward zero.
  function automatic logic [31:0] edge_blend(longint u, logic signed [31:0] p,
                                             longint v, logic signed [31:0] q);
    logic signed [127:0] wu, wv, pp, qq, quo;
    wu = {64'd0, u};
    wv = {64'd0, v};
    pp = p;
    qq = q;
    quo = (wu * pp + wv * qq) / (wu + wv);
    return quo[31:0];
  endfunction

  function automatic feature_t on_vertex(region_t rc, logic signed [31:0] px,
                                         logic signed [31:0] py);
    feature_t r;
    r.cnt = 2'd1;
    r.reg_code = rc;
    foreach (r.f[i]) r.f[i] = '0;
    r.f[0] = px; r.f[1] = py; r.f[6] = px; r.f[7] = py;
    return r;
  endfunction

  function automatic feature_t on_edge(region_t rc, longint u, longint v,
                                       logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] qx, logic signed [31:0] qy);
    feature_t r;
    r.cnt = 2'd2;
    r.reg_code = rc;
    foreach (r.f[i]) r.f[i] = '0;
    r.f[0] = px; r.f[1] = py; r.f[2] = qx; r.f[3] = qy;
    r.f[6] = edge_blend(u, px, v, qx);
    r.f[7] = edge_blend(u, py, v, qy);
    return r;
  endfunction

  function automatic feature_t closest_feature(logic [1:0] n,
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] bx,
      logic signed [31:0] by, logic signed [31:0] cx, logic signed [31:0] cy);
    longint u_ab, v_ab, u_bc, v_bc, u_ca, v_ca;
    int sa, su, sv, sw;
    feature_t r;
    u_ab = edge_weight(ax, ay, bx, by);
    v_ab = edge_weight(bx, by, ax, ay);
    u_bc = edge_weight(bx, by, cx, cy);
    v_bc = edge_weight(cx, cy, bx, by);
    u_ca = edge_weight(cx, cy, ax, ay);
    v_ca = edge_weight(ax, ay, cx, cy);
    if (n <= 2'd1) return on_vertex(REG_A, ax, ay);
    if (n == 2'd2) begin
      if (v_ab <= 0) return on_vertex(REG_A, ax, ay);
      if (u_ab <= 0) return on_vertex(REG_B, bx, by);
      return on_edge(REG_AB, u_ab, v_ab, ax, ay, bx, by);
    end
    if (v_ab <= 0 && u_ca <= 0) return on_vertex(REG_A, ax, ay);
    if (u_ab <= 0 && v_bc <= 0) return on_vertex(REG_B, bx, by);
    if (u_bc <= 0 && v_ca <= 0) return on_vertex(REG_C, cx, cy);
    sa = cross_sign(bx - ax, by - ay, cx - ax, cy - ay);
    su = cross_sign(bx, by, cx, cy);
    sv = cross_sign(cx, cy, ax, ay);
    sw = cross_sign(ax, ay, bx, by);
    if (u_ab > 0 && v_ab > 0 && sw * sa <= 0)
      return on_edge(REG_AB, u_ab, v_ab, ax, ay, bx, by);
    if (u_bc > 0 && v_bc > 0 && su * sa <= 0)
      return on_edge(REG_BC, u_bc, v_bc, bx, by, cx, cy);
    if (u_ca > 0 && v_ca > 0 && sv * sa <= 0)
      return on_edge(REG_CA, u_ca, v_ca, cx, cy, ax, ay);
    r.cnt = 2'd3;
    r.reg_code = REG_TRI;
    r.f = '{ax, ay, bx, by, cx, cy, 32'd0, 32'd0};
    return r;
  endfunction

  task automatic send_simplex(logic [1:0] n, logic signed [31:0] ax, logic signed [31:0] ay,
                              logic signed [31:0] bx, logic signed [31:0] by,
                              logic signed [31:0] cx, logic signed [31:0] cy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_count <= n;
    a_x <= ax; a_y <= ay; b_x <= bx; b_y <= by; c_x <= cx; c_y <= cy;
    do @(posedge clk); while (in_stall);
    pending_features.push_back(closest_feature(n, ax, ay, bx, by, cx, cy));
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    feature_t exp_f;
    logic [31:0] got[8];
    bit bad;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_features.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing outstanding");
      end else begin
        exp_f = pending_features.pop_front();
        got = '{out_a_x, out_a_y, out_b_x, out_b_y, out_c_x, out_c_y, closest_x, closest_y};
        bad = (reduced_count !== exp_f.cnt) || (region !== exp_f.reg_code);
        foreach (got[i]) if (got[i] !== exp_f.f[i]) bad = 1'b1;
        if (exp_f.reg_code <= REG_TRI) region_hits[exp_f.reg_code]++;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d cnt %0d/%0d region %0d/%0d (exp/got)",
                     results_seen, exp_f.cnt, reduced_count, exp_f.reg_code, region);
            foreach (got[i])
              $display("  field %0d exp %h got %h", i, exp_f.f[i], got[i]);
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      6: return $urandom;
      7: case ($urandom_range(3))
           0: return MAXC;
           1: return MINC;
           2: return 32'sd0;
           default: return -32'sd1;
         endcase
      8: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  task automatic test_vertex_cases();
    send_simplex(2'd0, ONE, -ONE, MAXC, MINC, MAXC, MAXC);
    send_simplex(2'd1, MAXC, MINC, ONE, ONE, ONE, ONE);
    send_simplex(2'd1, MINC, MAXC, 0, 0, 0, 0);
    send_simplex(2'd2, ONE, ONE, 2 * ONE, 3 * ONE, 0, 0);       // A nearest
    send_simplex(2'd2, 3 * ONE, ONE, ONE, 2 * ONE, 0, 0);       // B nearest
    send_simplex(2'd2, ONE, ONE, ONE, ONE, 0, 0);               // degenerate edge
    send_simplex(2'd3, ONE, ONE, 3 * ONE, ONE, ONE, 3 * ONE);
    send_simplex(2'd3, 3 * ONE, ONE, ONE, ONE, ONE, 3 * ONE);
    send_simplex(2'd3, 3 * ONE, ONE, ONE, 3 * ONE, ONE, ONE);
  endtask

  task automatic test_edge_cases();
    send_simplex(2'd2, -ONE, ONE, 3 * ONE, ONE, 0, 0);
    send_simplex(2'd2, -3 * ONE, -ONE, 5 * ONE, 2 * ONE, 0, 0);
    send_simplex(2'd3, -ONE, ONE, ONE, ONE, 0, 3 * ONE);        // AB
    send_simplex(2'd3, 0, 3 * ONE, -ONE, ONE, ONE, ONE);        // BC
    send_simplex(2'd3, ONE, ONE, 0, 3 * ONE, -ONE, ONE);        // CA
  endtask

  task automatic test_triangle_cases();
    send_simplex(2'd3, -ONE, -ONE, ONE, -ONE, 0, ONE);
    send_simplex(2'd3, 0, ONE, ONE, -ONE, -ONE, -ONE);
    send_simplex(2'd3, 0, 0, ONE, 0, 0, ONE);
  endtask

  task automatic test_wrapping_cases();
    send_simplex(2'd2, MAXC, MAXC, MINC, MINC, 0, 0);
    send_simplex(2'd2, MINC, MAXC, MAXC, MINC, 0, 0);
    send_simplex(2'd3, MAXC, MINC, MINC, MAXC, MAXC, MAXC);
    send_simplex(2'd3, MINC, MINC, MAXC, 0, 0, MAXC);
    send_simplex(2'd3, -1, -1, MAXC, -1, -1, MAXC);
  endtask

  task automatic test_random_items(int count, int s_pct, int r_pct);
    logic [1:0] n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      n = ($urandom_range(19) == 0) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3));
      send_simplex(n, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_vertex_cases();
    test_edge_cases();
    test_triangle_cases();
    test_wrapping_cases();
    go_quiet();
    test_random_items(150, 24, 79);
    test_random_items(150, 79, 24);
    test_random_items(150, 0, 0);
    go_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results; regions A %0d B %0d C %0d AB %0d BC %0d CA %0d tri %0d",
             results_seen, region_hits[0], region_hits[1], region_hits[2],
             region_hits[3], region_hits[4], region_hits[5], region_hits[6]);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_features.size() == 0) begin
      $display("gjk_simplex_closest_point verification clean");
    end else begin
      $display("gjk_simplex_closest_point verification failed");
    end
    $finish;
  end

endmodule
